### hw/rtl/cmcf_pkg.sv
// Shared widths, face codes and the pipeline record for the cube map face unit.
`default_nettype none

package cmcf_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int COORD_BITS     = 16;

    localparam int MAG_W = COMPONENT_BITS;
    localparam int SUM_W = COMPONENT_BITS + 1;

    localparam int IN_TDATA_W  = ((3 * COMPONENT_BITS + 7) / 8) * 8;
    localparam int FACE_W      = 3;
    localparam int OUT_TDATA_W = ((FACE_W + 2 * COORD_BITS + 7) / 8) * 8;

    typedef logic [FACE_W-1:0] face_t;

    localparam face_t FACE_FRONT  = 3'd0;
    localparam face_t FACE_RIGHT  = 3'd1;
    localparam face_t FACE_BEHIND = 3'd2;
    localparam face_t FACE_LEFT   = 3'd3;
    localparam face_t FACE_TOP    = 3'd4;
    localparam face_t FACE_BOTTOM = 3'd5;

    typedef struct packed {
        face_t                 face;
        logic                  invalid;
        logic                  sat_u;
        logic                  sat_v;
        logic [SUM_W-1:0]      divisor;
        logic [SUM_W-1:0]      rem_u;
        logic [SUM_W-1:0]      rem_v;
        logic [COORD_BITS-1:0] quo_u;
        logic [COORD_BITS-1:0] quo_v;
    } stage_t;

endpackage

`default_nettype wire

### hw/rtl/cmcf_select.sv
// Major axis and face selection, numerator and divisor setup for the divider chain.
`default_nettype none

module cmcf_select
    import cmcf_pkg::*;
(
    input  wire logic signed [COMPONENT_BITS-1:0] dir_x,
    input  wire logic signed [COMPONENT_BITS-1:0] dir_y,
    input  wire logic signed [COMPONENT_BITS-1:0] dir_z,
    output stage_t                                 stage
);

    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;
    logic [MAG_W-1:0]        az;
    logic signed [SUM_W-1:0] xs;
    logic signed [SUM_W-1:0] ys;
    logic signed [SUM_W-1:0] zs;
    logic signed [SUM_W-1:0] nu;
    logic signed [SUM_W-1:0] nv;
    logic signed [SUM_W-1:0] dext;
    logic [MAG_W-1:0]        d;
    logic [SUM_W-1:0]        sum_u;
    logic [SUM_W-1:0]        sum_v;
    logic [SUM_W-1:0]        div2;
    logic                    z_pos;
    face_t                   face;
    logic                    invalid;

    always_comb
    begin
        ax = dir_x[COMPONENT_BITS-1] ? MAG_W'(-dir_x) : MAG_W'(dir_x);
        ay = dir_y[COMPONENT_BITS-1] ? MAG_W'(-dir_y) : MAG_W'(dir_y);
        az = dir_z[COMPONENT_BITS-1] ? MAG_W'(-dir_z) : MAG_W'(dir_z);
        xs = SUM_W'(dir_x);
        ys = SUM_W'(dir_y);
        zs = SUM_W'(dir_z);
        z_pos = !dir_z[COMPONENT_BITS-1] && (dir_z != '0);

        if (ax > ay)
        begin
            if (ax > az)
                face = dir_x[COMPONENT_BITS-1] ? FACE_LEFT : FACE_RIGHT;
            else
                face = z_pos ? FACE_FRONT : FACE_BEHIND;
        end
        else
        begin
            if (ay > az)
                face = dir_y[COMPONENT_BITS-1] ? FACE_BOTTOM : FACE_TOP;
            else
                face = z_pos ? FACE_FRONT : FACE_BEHIND;
        end

        case (face)
            FACE_FRONT:
            begin
                d = az; nu = xs; nv = -ys;
            end
            FACE_BEHIND:
            begin
                d = az; nu = -xs; nv = -ys;
            end
            FACE_RIGHT:
            begin
                d = ax; nu = -zs; nv = -ys;
            end
            FACE_LEFT:
            begin
                d = ax; nu = zs; nv = -ys;
            end
            FACE_TOP:
            begin
                d = ay; nu = xs; nv = zs;
            end
            default:
            begin
                d = ay; nu = xs; nv = -zs;
            end
        endcase

        invalid = (d == '0);
        dext    = {1'b0, d};
        sum_u   = SUM_W'(nu + dext);
        sum_v   = SUM_W'(nv + dext);
        div2    = {d, 1'b0};

        stage.face    = face;
        stage.invalid = invalid;
        stage.sat_u   = (sum_u == div2) && !invalid;
        stage.sat_v   = (sum_v == div2) && !invalid;
        stage.divisor = div2;
        stage.rem_u   = (sum_u == div2) ? '0 : sum_u;
        stage.rem_v   = (sum_v == div2) ? '0 : sum_v;
        stage.quo_u   = '0;
        stage.quo_v   = '0;
    end

endmodule

`default_nettype wire

### hw/rtl/cmcf_cell.sv
// One divider cell: resolves one quotient bit of both coordinates and holds the beat.
`default_nettype none

module cmcf_cell
    import cmcf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire stage_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output stage_t      out_data
);

    logic               valid_reg;
    logic               valid_next;
    stage_t             data_reg;
    stage_t             data_next;
    logic [SUM_W:0]     r2_u;
    logic [SUM_W:0]     r2_v;
    logic               ge_u;
    logic               ge_v;

    always_comb
    begin
        in_ready  = !valid_reg || out_ready;
        valid_next = in_ready ? in_valid : valid_reg;

        r2_u = {in_data.rem_u, 1'b0};
        r2_v = {in_data.rem_v, 1'b0};
        ge_u = r2_u >= {1'b0, in_data.divisor};
        ge_v = r2_v >= {1'b0, in_data.divisor};

        data_next       = in_data;
        data_next.rem_u = ge_u ? SUM_W'(r2_u - {1'b0, in_data.divisor}) : SUM_W'(r2_u);
        data_next.rem_v = ge_v ? SUM_W'(r2_v - {1'b0, in_data.divisor}) : SUM_W'(r2_v);
        data_next.quo_u = {in_data.quo_u[COORD_BITS-2:0], ge_u};
        data_next.quo_v = {in_data.quo_v[COORD_BITS-2:0], ge_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### hw/rtl/cube_map_face_and_coord.sv
// Top level of the cube map face and face coordinate unit.
// Takes one direction beat per cycle while not stalled and returns one result beat per
// direction, in order. A chain of COORD_BITS divider cells, each resolving one quotient
// bit of both coordinates, is followed by the output register. Throughput is one beat
// per cycle unless the output stalls; a stall on the output side fills bubbles in the
// chain before it reaches the input side. invalid flags the all-zero direction, which
// reports the behind face with both coordinates zero; an exact edge saturates to all ones.
`default_nettype none

module cube_map_face_and_coord
    import cmcf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // dir_x, dir_y, dir_z
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // face, coord_u, coord_v
    output logic [0:0]                  m_axis_tuser   // invalid
);

    stage_t                    chain_data  [COORD_BITS+1];
    logic [COORD_BITS:0]       chain_valid;
    logic [COORD_BITS:0]       chain_ready;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_load;
    face_t                     face_reg;
    logic [COORD_BITS-1:0]     coord_u_reg;
    logic [COORD_BITS-1:0]     coord_v_reg;
    logic                      invalid_reg;
    logic [COORD_BITS-1:0]     coord_u_next;
    logic [COORD_BITS-1:0]     coord_v_next;
    stage_t                    last;

    cmcf_select u_select
    (
        .dir_x (s_axis_tdata[COMPONENT_BITS-1:0]),
        .dir_y (s_axis_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS]),
        .dir_z (s_axis_tdata[3*COMPONENT_BITS-1:2*COMPONENT_BITS]),
        .stage (chain_data[0])
    );

    assign chain_valid[0] = s_axis_tvalid;
    assign s_axis_tready  = chain_ready[0];

    for (genvar i = 0; i < COORD_BITS; i++)
    begin : g_cell
        cmcf_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign chain_ready[COORD_BITS] = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        last = chain_data[COORD_BITS];
        out_load       = chain_ready[COORD_BITS] && chain_valid[COORD_BITS];
        out_valid_next = chain_ready[COORD_BITS] ? chain_valid[COORD_BITS] : out_valid_reg;

        if (last.invalid)
            coord_u_next = '0;
        else if (last.sat_u)
            coord_u_next = '1;
        else
            coord_u_next = last.quo_u;

        if (last.invalid)
            coord_v_next = '0;
        else if (last.sat_v)
            coord_v_next = '1;
        else
            coord_v_next = last.quo_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            face_reg    <= last.face;
            coord_u_reg <= coord_u_next;
            coord_v_reg <= coord_v_next;
            invalid_reg <= last.invalid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({coord_v_reg, coord_u_reg, face_reg});
    assign m_axis_tuser  = invalid_reg;

endmodule

`default_nettype wire

### hw/rtl/cmcf_checker.sv
// Port-level checks for the cube map face unit, bound to the top level.
`default_nettype none

module cmcf_checker
    import cmcf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [0:0]             m_axis_tuser
);

    face_t                 face;
    logic [COORD_BITS-1:0] coord_u;
    logic [COORD_BITS-1:0] coord_v;

    assign face    = m_axis_tdata[FACE_W-1:0];
    assign coord_u = m_axis_tdata[FACE_W+COORD_BITS-1:FACE_W];
    assign coord_v = m_axis_tdata[FACE_W+2*COORD_BITS-1:FACE_W+COORD_BITS];

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_invalid_face: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> face == FACE_BEHIND)
        else $error("zero direction not reported on behind face");

    a_invalid_coords: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> coord_u == '0 && coord_v == '0)
        else $error("zero direction with nonzero coordinates");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> face <= FACE_BOTTOM)
        else $error("face code out of range");

endmodule

bind cube_map_face_and_coord cmcf_checker u_cmcf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
